### design/bdm_pkg.sv
// bdm_pkg: shared types, constants and codes for the backwater depth march block
// no dependencies
`default_nettype none

package bdm_pkg;

    localparam int ALU_W         = 120;
    localparam int QUO_W         = 64;
    localparam int CNT_W         = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int MAX_STEPS_DEF = 1024;

    // gravity in Q16.16, rounding half in Q0.24, one in Q1.24
    localparam logic [19:0] G_Q16    = 20'd642908;
    localparam logic [23:0] HALF_Q24 = 24'h800000;
    localparam logic [24:0] ONE_Q24  = 25'h1000000;
    localparam logic [40:0] FN_LIMIT = 41'h100_0000_0000;

    localparam logic [CNT_W-1:0] FR_DIV_STEPS = 7'd24;
    localparam logic [CNT_W-1:0] SL_DIV_STEPS = 7'd40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DWL          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CF_SAND      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CF_GRAVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_SAND       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_GRAVEL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAND_STEPS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVEL_STEPS = 3'd6;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FROUDE = 2'd1;
    localparam logic [1:0] ST_ZERO   = 2'd2;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DCHK,
        A_DIV
    } alu_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QQ,
        S_HH,
        S_HHH,
        S_HG,
        S_FDIV,
        S_CF,
        S_DX,
        S_SDIV,
        S_EVAL,
        S_RES
    } seq_state_t;

    typedef struct packed {
        logic             go;
        alu_op_t          op;
        logic [ALU_W-1:0] x;
        logic [ALU_W-1:0] y;
        logic [CNT_W-1:0] steps;
    } alu_cmd_t;

    typedef struct packed {
        logic             idle;
        logic             done;
        logic             ovf;
        logic [ALU_W-1:0] acc;
        logic [QUO_W-1:0] quo;
    } alu_res_t;

    typedef struct packed {
        logic [31:0] dwl;
        logic [23:0] cf_sand;
        logic [23:0] cf_gravel;
        logic [31:0] q_sand;
        logic [31:0] q_gravel;
        logic [10:0] sand_steps;
        logic [10:0] gravel_steps;
    } cfg_t;

endpackage

`default_nettype wire

### design/bdm_if.sv
// bdm_if: valid/ready channel interfaces for nodes, profile results and config writes
// depends on bdm_pkg for widths
`default_nettype none

interface bdm_node_if;
    logic        valid;
    logic        ready;
    logic        start_req;
    logic [31:0] bed_elevation;
    logic [39:0] position;

    modport source (output valid, start_req, bed_elevation, position, input ready);
    modport sink (input valid, start_req, bed_elevation, position, output ready);
endinterface

interface bdm_prof_if;
    logic        valid;
    logic        ready;
    logic [31:0] depth;
    logic [11:0] step_index;
    logic [1:0]  status;
    logic        run_done;

    modport source (output valid, depth, step_index, status, run_done, input ready);
    modport sink (input valid, depth, step_index, status, run_done, output ready);
endinterface

interface bdm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bdm_pkg::CFG_IDX_W-1:0]  index;
    logic [bdm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/backwater_depth_march.sv
// backwater_depth_march: top level of the upstream backwater depth marcher
// depends on bdm_pkg, bdm_if, bdm_cfg, bdm_alu and bdm_seq
//
// usage
// - node channel: one transfer per river node; start_req marks the downstream
//   boundary node, later transfers walk upstream with bed elevation and position
// - profile channel: one transfer per node of an active run with depth, step
//   index, status and run_done; nodes outside a run are dropped with no result
// - cfg channel: register index and data, always ready; write only while idle
// - a boundary node's result is registered once the output register is free
// - an upstream node runs two Froude/slope passes through one bit-serial
//   shift-add / restoring-divide unit, with 24 and 40 bit divides; a Froude
//   error ends the node early
// - node ready is high only while the sequencer is idle, so one node at a time
// - the result sits in an output register; the next node is taken while it
//   waits, but that node cannot finish until the register is free
// - reset clears the run state, the stored depth, elevation, position and step
//   counter, and loads the register defaults
`default_nettype none

module backwater_depth_march #(
    parameter int MAX_STEPS = bdm_pkg::MAX_STEPS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bdm_node_if.sink   node,
    bdm_prof_if.source profile,
    bdm_cfg_if.sink    cfg
);

    bdm_pkg::cfg_t     regs;
    bdm_pkg::alu_cmd_t alu_cmd;
    bdm_pkg::alu_res_t alu_res;

    // configuration registers
    bdm_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // shared multiply / divide unit
    bdm_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (alu_cmd),
        .res   (alu_res)
    );

    // step sequencer with run state and result register
    bdm_seq #(
        .MAX_STEPS (MAX_STEPS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .node    (node),
        .profile (profile),
        .regs    (regs),
        .alu_cmd (alu_cmd),
        .alu_res (alu_res)
    );

`ifndef SYNTHESIS
    // the unit only takes a command when it has nothing in flight
    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        alu_cmd.go |-> alu_res.idle)
        else $error("shared unit issued while busy");

    // nodes are only taken while the unit is idle
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        node.ready |-> alu_res.idle)
        else $error("node ready while unit busy");

    // a boundary node goes straight to the result stage
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (node.valid && node.ready && node.start_req) |=> !node.ready)
        else $error("ready after boundary node transfer");

    // completion is a single-cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        alu_res.done |=> !alu_res.done)
        else $error("unit done held");
`endif

endmodule

`default_nettype wire

### design/bdm_cfg.sv
// bdm_cfg: configuration register file written over the config channel
// depends on bdm_pkg and bdm_if
`default_nettype none

module bdm_cfg (
    input  wire logic      clk,
    input  wire logic      rst_n,
    bdm_cfg_if.sink        cfg,
    output bdm_pkg::cfg_t  regs
);

    bdm_pkg::cfg_t regs_reg;
    bdm_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                bdm_pkg::CFG_DWL:          regs_next.dwl          = cfg.data;
                bdm_pkg::CFG_CF_SAND:      regs_next.cf_sand      = cfg.data[23:0];
                bdm_pkg::CFG_CF_GRAVEL:    regs_next.cf_gravel    = cfg.data[23:0];
                bdm_pkg::CFG_Q_SAND:       regs_next.q_sand       = cfg.data;
                bdm_pkg::CFG_Q_GRAVEL:     regs_next.q_gravel     = cfg.data;
                bdm_pkg::CFG_SAND_STEPS:   regs_next.sand_steps   = cfg.data[10:0];
                bdm_pkg::CFG_GRAVEL_STEPS: regs_next.gravel_steps = cfg.data[10:0];
                default:                   regs_next              = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.dwl          <= 32'd0;
            regs_reg.cf_sand      <= 24'd83886;
            regs_reg.cf_gravel    <= 24'd83886;
            regs_reg.q_sand       <= 32'd65536;
            regs_reg.q_gravel     <= 32'd65536;
            regs_reg.sand_steps   <= 11'd0;
            regs_reg.gravel_steps <= 11'd0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

### design/bdm_alu.sv
// bdm_alu: shared bit-serial shift-add multiplier and restoring divider
// depends on bdm_pkg
`default_nettype none

module bdm_alu (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  bdm_pkg::alu_cmd_t  cmd,
    output bdm_pkg::alu_res_t  res
);

    localparam int W = bdm_pkg::ALU_W;
    localparam int Q = bdm_pkg::QUO_W;

    bdm_pkg::alu_state_t state_reg, state_next;
    logic [W-1:0]              acc_reg, acc_next;
    logic [W-1:0]              opnd_reg, opnd_next;
    logic [Q-1:0]              qb_reg, qb_next;
    logic [bdm_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      done_reg, done_next;
    logic                      ovf_reg, ovf_next;

    logic [W-1:0] sh;
    logic [W:0]   diff;
    logic         ge;
    logic [W-1:0] sum;

    // one subtractor serves the overflow check and every divide step
    assign sh   = (state_reg == bdm_pkg::A_DCHK) ? acc_reg : {acc_reg[W-2:0], 1'b0};
    assign diff = {1'b0, sh} - {1'b0, opnd_reg};
    assign ge   = !diff[W];
    assign sum  = acc_reg + (qb_reg[0] ? opnd_reg : {W{1'b0}});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdm_pkg::A_IDLE:
            begin
                if (cmd.go)
                begin
                    state_next = (cmd.op == bdm_pkg::ALU_MUL) ? bdm_pkg::A_MUL
                                                              : bdm_pkg::A_DCHK;
                end
            end
            bdm_pkg::A_MUL:
            begin
                if (qb_reg == '0)
                begin
                    state_next = bdm_pkg::A_IDLE;
                end
            end
            bdm_pkg::A_DCHK:
            begin
                state_next = ge ? bdm_pkg::A_IDLE : bdm_pkg::A_DIV;
            end
            bdm_pkg::A_DIV:
            begin
                if (cnt_reg == bdm_pkg::CNT_W'(1))
                begin
                    state_next = bdm_pkg::A_IDLE;
                end
            end
            default: state_next = bdm_pkg::A_IDLE;
        endcase
    end

    always_comb
    begin
        acc_next  = acc_reg;
        opnd_next = opnd_reg;
        qb_next   = qb_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        unique case (state_reg)
            bdm_pkg::A_IDLE:
            begin
                if (cmd.go)
                begin
                    ovf_next = 1'b0;
                    cnt_next = cmd.steps;
                    if (cmd.op == bdm_pkg::ALU_MUL)
                    begin
                        acc_next  = '0;
                        opnd_next = cmd.x;
                        qb_next   = cmd.y[Q-1:0];
                    end
                    else
                    begin
                        acc_next  = cmd.x;
                        opnd_next = cmd.y;
                        qb_next   = '0;
                    end
                end
            end
            bdm_pkg::A_MUL:
            begin
                if (qb_reg == '0)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    acc_next  = sum;
                    opnd_next = {opnd_reg[W-2:0], 1'b0};
                    qb_next   = {1'b0, qb_reg[Q-1:1]};
                end
            end
            bdm_pkg::A_DCHK:
            begin
                if (ge)
                begin
                    ovf_next  = 1'b1;
                    done_next = 1'b1;
                end
            end
            bdm_pkg::A_DIV:
            begin
                acc_next = ge ? diff[W-1:0] : sh;
                qb_next  = {qb_reg[Q-2:0], ge};
                cnt_next = cnt_reg - bdm_pkg::CNT_W'(1);
                if (cnt_reg == bdm_pkg::CNT_W'(1))
                begin
                    done_next = 1'b1;
                end
            end
            default: done_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdm_pkg::A_IDLE;
            done_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        opnd_reg <= opnd_next;
        qb_reg   <= qb_next;
        cnt_reg  <= cnt_next;
    end

    assign res.idle = (state_reg == bdm_pkg::A_IDLE);
    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.acc  = acc_reg;
    assign res.quo  = qb_reg;

endmodule

`default_nettype wire

### design/bdm_seq.sv
// bdm_seq: step sequencer, run state and result register of the depth march
// depends on bdm_pkg and bdm_if; drives the shared unit bdm_alu through its ports
`default_nettype none

module bdm_seq #(
    parameter int MAX_STEPS = bdm_pkg::MAX_STEPS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    bdm_node_if.sink           node,
    bdm_prof_if.source         profile,
    input  bdm_pkg::cfg_t      regs,
    output bdm_pkg::alu_cmd_t  alu_cmd,
    input  bdm_pkg::alu_res_t  alu_res
);

    localparam int          W     = bdm_pkg::ALU_W;
    localparam logic [16:0] MAX_W = 17'(MAX_STEPS);

    bdm_pkg::seq_state_t state_reg, state_next;

    logic        issued_reg, issued_next;
    logic        pass_reg, pass_next;
    logic        neg_reg, neg_next;
    logic        active_reg, active_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] elev_reg, elev_next;
    logic [39:0] pos_reg, pos_next;
    logic [11:0] step_reg, step_next;
    logic [11:0] n_reg, n_next;
    logic [31:0] bed_reg, bed_next;
    logic [39:0] posi_reg, posi_next;
    logic        sand_sel_reg, sand_sel_next;
    logic [40:0] dx_reg, dx_next;
    logic [32:0] deta_reg, deta_next;
    logic [31:0] hc_reg, hc_next;
    logic [63:0] qsq_reg, qsq_next;
    logic [23:0] f_reg, f_next;
    logic [41:0] fnp_reg, fnp_next;
    logic [41:0] fn_reg, fn_next;
    logic [31:0] dres_reg, dres_next;
    logic [1:0]  sres_reg, sres_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_depth_reg, out_depth_next;
    logic [11:0] out_step_reg, out_step_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic        out_done_reg, out_done_next;

    logic        node_ready;
    logic        op_done;
    logic        slot_free;
    logic [23:0] cf_sel;
    logic [31:0] q_sel;
    logic [32:0] h_start;
    logic [11:0] n_inc;
    logic [48:0] p24_sum;
    logic [40:0] mdx;
    logic [66:0] m_sum;
    logic [43:0] fric;
    logic [43:0] num;
    logic [43:0] mag;
    logic [24:0] den;
    logic [40:0] res41;
    logic [43:0] hp;
    logic        hp_bad;
    logic [44:0] t_sum;
    logic [44:0] u_sum;
    logic [11:0] sum_steps;
    logic [16:0] total;
    logic        run_end;

    assign op_done   = issued_reg && alu_res.done;
    assign slot_free = !out_valid_reg || profile.ready;
    assign cf_sel    = sand_sel_reg ? regs.cf_sand : regs.cf_gravel;
    assign q_sel     = sand_sel_reg ? regs.q_sand : regs.q_gravel;

    // boundary depth from the downstream level
    assign h_start = {regs.dwl[31], regs.dwl} - {node.bed_elevation[31], node.bed_elevation};
    assign n_inc   = step_reg + 12'd1;

    // friction slope pieces, each rounded half up
    assign p24_sum = {1'b0, alu_res.acc[47:0]} + 49'(bdm_pkg::HALF_Q24);
    assign mdx     = dx_reg[40] ? (41'd0 - dx_reg) : dx_reg;
    assign m_sum   = {1'b0, alu_res.acc[65:0]} + 67'(bdm_pkg::HALF_Q24);
    assign fric    = dx_reg[40] ? (44'd0 - {1'b0, m_sum[66:24]}) : {1'b0, m_sum[66:24]};
    assign num     = {{11{deta_reg[32]}}, deta_reg} - fric;
    assign mag     = num[43] ? (44'd0 - num) : num;
    assign den     = bdm_pkg::ONE_Q24 - {1'b0, f_reg};
    assign res41   = alu_res.ovf ? bdm_pkg::FN_LIMIT : {1'b0, alu_res.quo[39:0]};

    // predictor and corrector combinations
    assign hp     = {12'd0, h_reg} - {{2{fn_reg[41]}}, fn_reg};
    assign hp_bad = hp[43] || (hp == 44'd0);
    assign t_sum  = {12'd0, h_reg, 1'b0} - {{3{fnp_reg[41]}}, fnp_reg}
                  - {{3{fn_reg[41]}}, fn_reg};
    assign u_sum  = t_sum + 45'd1;

    assign sum_steps = {1'b0, regs.sand_steps} + {1'b0, regs.gravel_steps};
    assign total     = (17'(sum_steps) > MAX_W) ? MAX_W : 17'(sum_steps);
    assign run_end   = (17'(n_reg) >= total);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdm_pkg::S_IDLE:
            begin
                if (node.valid)
                begin
                    if (node.start_req)
                    begin
                        state_next = bdm_pkg::S_RES;
                    end
                    else if (active_reg)
                    begin
                        state_next = bdm_pkg::S_QQ;
                    end
                end
            end
            bdm_pkg::S_QQ:   if (op_done) state_next = bdm_pkg::S_HH;
            bdm_pkg::S_HH:   if (op_done) state_next = bdm_pkg::S_HHH;
            bdm_pkg::S_HHH:  if (op_done) state_next = bdm_pkg::S_HG;
            bdm_pkg::S_HG:   if (op_done) state_next = bdm_pkg::S_FDIV;
            bdm_pkg::S_FDIV:
            begin
                if (op_done)
                begin
                    state_next = alu_res.ovf ? bdm_pkg::S_RES : bdm_pkg::S_CF;
                end
            end
            bdm_pkg::S_CF:   if (op_done) state_next = bdm_pkg::S_DX;
            bdm_pkg::S_DX:   if (op_done) state_next = bdm_pkg::S_SDIV;
            bdm_pkg::S_SDIV: if (op_done) state_next = bdm_pkg::S_EVAL;
            bdm_pkg::S_EVAL:
            begin
                if (!pass_reg && !hp_bad)
                begin
                    state_next = bdm_pkg::S_HH;
                end
                else
                begin
                    state_next = bdm_pkg::S_RES;
                end
            end
            bdm_pkg::S_RES:  if (slot_free) state_next = bdm_pkg::S_IDLE;
            default:         state_next = bdm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        node_ready      = 1'b0;
        alu_cmd         = '0;
        issued_next     = issued_reg;
        pass_next       = pass_reg;
        neg_next        = neg_reg;
        active_next     = active_reg;
        h_next          = h_reg;
        elev_next       = elev_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        n_next          = n_reg;
        bed_next        = bed_reg;
        posi_next       = posi_reg;
        sand_sel_next   = sand_sel_reg;
        dx_next         = dx_reg;
        deta_next       = deta_reg;
        hc_next         = hc_reg;
        qsq_next        = qsq_reg;
        f_next          = f_reg;
        fnp_next        = fnp_reg;
        fn_next         = fn_reg;
        dres_next       = dres_reg;
        sres_next       = sres_reg;
        out_valid_next  = out_valid_reg && !profile.ready;
        out_depth_next  = out_depth_reg;
        out_step_next   = out_step_reg;
        out_status_next = out_status_reg;
        out_done_next   = out_done_reg;

        unique case (state_reg)
            bdm_pkg::S_IDLE:
            begin
                node_ready = 1'b1;
                if (node.valid)
                begin
                    bed_next  = node.bed_elevation;
                    posi_next = node.position;
                    sres_next = bdm_pkg::ST_OK;
                    if (node.start_req)
                    begin
                        n_next = 12'd0;
                        if (h_start[32] || (h_start == 33'd0))
                        begin
                            dres_next = 32'd0;
                            sres_next = bdm_pkg::ST_ZERO;
                        end
                        else
                        begin
                            dres_next = h_start[31:0];
                        end
                    end
                    else
                    begin
                        n_next        = n_inc;
                        sand_sel_next = ({1'b0, regs.sand_steps} >= n_inc);
                        dx_next       = {1'b0, pos_reg} - {1'b0, node.position};
                        deta_next     = {node.bed_elevation[31], node.bed_elevation}
                                      - {elev_reg[31], elev_reg};
                        hc_next       = h_reg;
                        pass_next     = 1'b0;
                    end
                end
            end
            bdm_pkg::S_QQ:
            begin
                alu_cmd.go = !issued_reg;
                alu_cmd.op = bdm_pkg::ALU_MUL;
                alu_cmd.x  = W'(q_sel);
                alu_cmd.y  = W'(q_sel);
                if (op_done)
                begin
                    qsq_next = alu_res.acc[63:0];
                end
            end
            bdm_pkg::S_HH:
            begin
                alu_cmd.go = !issued_reg;
                alu_cmd.op = bdm_pkg::ALU_MUL;
                alu_cmd.x  = W'(hc_reg);
                alu_cmd.y  = W'(hc_reg);
            end
            bdm_pkg::S_HHH:
            begin
                alu_cmd.go = !issued_reg;
                alu_cmd.op = bdm_pkg::ALU_MUL;
                alu_cmd.x  = alu_res.acc;
                alu_cmd.y  = W'(hc_reg);
            end
            bdm_pkg::S_HG:
            begin
                alu_cmd.go = !issued_reg;
                alu_cmd.op = bdm_pkg::ALU_MUL;
                alu_cmd.x  = alu_res.acc;
                alu_cmd.y  = W'(bdm_pkg::G_Q16);
            end
            bdm_pkg::S_FDIV:
            begin
                // q^2 against g h^3, then 24 quotient bits of the Froude number squared
                alu_cmd.go    = !issued_reg;
                alu_cmd.op    = bdm_pkg::ALU_DIV;
                alu_cmd.x     = W'({qsq_reg, 32'd0});
                alu_cmd.y     = alu_res.acc;
                alu_cmd.steps = bdm_pkg::FR_DIV_STEPS;
                if (op_done)
                begin
                    if (alu_res.ovf)
                    begin
                        dres_next = h_reg;
                        sres_next = bdm_pkg::ST_FROUDE;
                    end
                    else
                    begin
                        f_next = alu_res.quo[23:0];
                    end
                end
            end
            bdm_pkg::S_CF:
            begin
                alu_cmd.go = !issued_reg;
                alu_cmd.op = bdm_pkg::ALU_MUL;
                alu_cmd.x  = W'(cf_sel);
                alu_cmd.y  = W'(f_reg);
            end
            bdm_pkg::S_DX:
            begin
                alu_cmd.go = !issued_reg;
                alu_cmd.op = bdm_pkg::ALU_MUL;
                alu_cmd.x  = W'(p24_sum[48:24]);
                alu_cmd.y  = W'(mdx);
            end
            bdm_pkg::S_SDIV:
            begin
                // magnitude over (1 - F), 40 quotient bits, saturating at the limit
                alu_cmd.go    = !issued_reg;
                alu_cmd.op    = bdm_pkg::ALU_DIV;
                alu_cmd.x     = W'(mag);
                alu_cmd.y     = W'({den, 16'd0});
                alu_cmd.steps = bdm_pkg::SL_DIV_STEPS;
                if (!issued_reg)
                begin
                    neg_next = num[43];
                end
                if (op_done)
                begin
                    fn_next = neg_reg ? (42'd0 - {1'b0, res41}) : {1'b0, res41};
                end
            end
            bdm_pkg::S_EVAL:
            begin
                if (!pass_reg)
                begin
                    if (hp_bad)
                    begin
                        dres_next = h_reg;
                        sres_next = bdm_pkg::ST_FROUDE;
                    end
                    else
                    begin
                        hc_next   = (hp[43:32] != 12'd0) ? 32'hFFFF_FFFF : hp[31:0];
                        fnp_next  = fn_reg;
                        pass_next = 1'b1;
                    end
                end
                else if (t_sum[44] || (t_sum == 45'd0))
                begin
                    dres_next = 32'd0;
                    sres_next = bdm_pkg::ST_ZERO;
                end
                else
                begin
                    dres_next = (u_sum[44:33] != 12'd0) ? 32'hFFFF_FFFF : u_sum[32:1];
                end
            end
            bdm_pkg::S_RES:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_depth_next  = dres_reg;
                    out_step_next   = n_reg;
                    out_status_next = sres_reg;
                    out_done_next   = run_end;
                    h_next          = dres_reg;
                    elev_next       = bed_reg;
                    pos_next        = posi_reg;
                    step_next       = n_reg;
                    active_next     = !run_end;
                end
            end
            default: node_ready = 1'b0;
        endcase

        if (alu_cmd.go)
        begin
            issued_next = 1'b1;
        end
        if (op_done)
        begin
            issued_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdm_pkg::S_IDLE;
            issued_reg    <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            h_reg         <= 32'd0;
            elev_reg      <= 32'd0;
            pos_reg       <= 40'd0;
            step_reg      <= 12'd0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            h_reg         <= h_next;
            elev_reg      <= elev_next;
            pos_reg       <= pos_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg       <= pass_next;
        neg_reg        <= neg_next;
        n_reg          <= n_next;
        bed_reg        <= bed_next;
        posi_reg       <= posi_next;
        sand_sel_reg   <= sand_sel_next;
        dx_reg         <= dx_next;
        deta_reg       <= deta_next;
        hc_reg         <= hc_next;
        qsq_reg        <= qsq_next;
        f_reg          <= f_next;
        fnp_reg        <= fnp_next;
        fn_reg         <= fn_next;
        dres_reg       <= dres_next;
        sres_reg       <= sres_next;
        out_depth_reg  <= out_depth_next;
        out_step_reg   <= out_step_next;
        out_status_reg <= out_status_next;
        out_done_reg   <= out_done_next;
    end

    assign node.ready         = node_ready;
    assign profile.valid      = out_valid_reg;
    assign profile.depth      = out_depth_reg;
    assign profile.step_index = out_step_reg;
    assign profile.status     = out_status_reg;
    assign profile.run_done   = out_done_reg;

endmodule

`default_nettype wire
